// File: hdl/qsel_pkg.sv
// Shared types and constants for the quickselect partition engine.
package qsel_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 9;
    localparam int KW    = 32;
    localparam int IN_DW  = 104;
    localparam int OUT_DW = 64;
    localparam int UW     = 2;

    typedef logic [PW-1:0] t_pos;
    typedef logic [AW-1:0] t_addr;

    typedef struct packed {
        logic [KW-1:0] payload;
        logic [KW-1:0] key;
    } t_entry;

    typedef enum logic [UW-1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_PARTITION = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

endpackage

// File: hdl/quickselect_partition_engine_unit.sv
// Quickselect partition engine: entry memory plus scan/swap sequencer.
//
//  channel | dir | bus          | contents (lowest bit up)
//  --------+-----+--------------+----------------------------------------------
//  s_axis  | in  | tuser[1:0]   | operation
//          |     | tdata[103:0] | position[8:0] key[40:9] payload[72:41]
//          |     |              | low_bound[81:73] target[90:82]
//          |     |              | high_bound[99:91] zero[103:100]
//  m_axis  | out | tdata[63:0]  | out_key[31:0] out_payload[63:32]
//
// One transaction at a time; s_axis_tready is high only while the sequencer
// is idle. A write or a read ends in the output register. A partition
// runs on the single-read, single-write entry memory: every outer pass
// loads the pivot, scans the range from both ends, exchanges each
// out-of-place pair, then exchanges the pivot into place; ranges of one
// entry or none skip the scan. The result sits in a registered m_axis stage,
// and the next transaction is accepted while it waits. Reset clears control
// state only; the memory holds no reset value and is not cleared.
module quickselect_partition_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // position, key, payload, low_bound, target, high_bound, zero pad
    input  logic [qsel_pkg::IN_DW-1:0]  i_s_axis_tdata,
    // operation
    input  logic [qsel_pkg::UW-1:0]     i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_key, out_payload
    output logic [qsel_pkg::OUT_DW-1:0] o_m_axis_tdata
);
    import qsel_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIV_LOAD,   // pivot key arrives, scan starts
        S_RES_LOAD,   // result entry arrives
        S_L_SCAN,     // upward scan
        S_H_SCAN,     // downward scan
        S_SWAP_A,
        S_SWAP_B,
        S_PIV_RD,     // entry at swap point arrives
        S_PIV_WA,
        S_PIV_WB,
        S_NEXT,
        S_RESP
    } t_state;

    function automatic t_addr to_addr(input t_pos p);
        t_pos d;
        d = p - PW'(1);
        return d[AW-1:0];
    endfunction

    function automatic logic pos_ok(input t_pos p);
        return (p != '0) && ({1'b0, p} <= (PW+1)'(DEPTH));
    endfunction

    // Entry memory: one write port, one registered read port.
    t_entry r_entry_mem [DEPTH];
    t_entry r_rd_data;
    t_addr  rd_addr;
    logic   wr_en;
    t_addr  wr_addr;
    t_entry wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entry_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_entry_mem[rd_addr];
    end

    // Input fields.
    t_op           in_op;
    t_pos          in_pos, in_lo, in_tg, in_hi;
    t_entry        in_entry;
    assign in_op            = t_op'(i_s_axis_tuser);
    assign in_pos           = i_s_axis_tdata[8:0];
    assign in_entry.key     = i_s_axis_tdata[40:9];
    assign in_entry.payload = i_s_axis_tdata[72:41];
    assign in_lo            = i_s_axis_tdata[81:73];
    assign in_tg            = i_s_axis_tdata[90:82];
    assign in_hi            = i_s_axis_tdata[99:91];

    t_state        r_state, n_state;
    t_pos          r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_l, n_l, r_h, n_h;
    logic [KW-1:0] r_pivot, n_pivot;
    t_entry        r_l_ent, n_l_ent, r_h_ent, n_h_ent, r_a, n_a, r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_entry        r_out_data, n_out_data;

    logic          accept;
    t_pos          h_final;
    t_pos          nx_lo, nx_hi;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Swap point after a scan, and the narrowed range after the pivot swap.
    assign h_final = (r_mid > r_h) ? r_l : r_h;
    assign nx_hi   = (r_h >= r_mid) ? r_h - PW'(1) : r_hi;
    assign nx_lo   = (r_h <= r_mid) ? r_h + PW'(1) : r_lo;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_l         = r_l;
        n_h         = r_h;
        n_pivot     = r_pivot;
        n_l_ent     = r_l_ent;
        n_h_ent     = r_h_ent;
        n_a         = r_a;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rd_addr     = to_addr(r_l);
        wr_en       = 1'b0;
        wr_addr     = to_addr(r_l);
        wr_data     = r_h_ent;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_RESP;
                    unique case (in_op)
                        OP_WRITE: begin
                            if (pos_ok(in_pos)) begin
                                wr_en   = 1'b1;
                                wr_addr = to_addr(in_pos);
                                wr_data = in_entry;
                            end
                        end
                        OP_READ: begin
                            if (pos_ok(in_pos)) begin
                                rd_addr = to_addr(in_pos);
                                n_state = S_RES_LOAD;
                            end
                        end
                        OP_PARTITION: begin
                            if (pos_ok(in_lo) && pos_ok(in_tg) && pos_ok(in_hi)) begin
                                n_lo    = in_lo;
                                n_hi    = in_hi;
                                n_mid   = in_tg;
                                rd_addr = to_addr(in_tg);
                                n_state = (in_hi > in_lo) ? S_PIV_LOAD : S_RES_LOAD;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PIV_LOAD: begin
                n_pivot = r_rd_data.key;
                n_l     = r_lo;
                n_h     = r_hi;
                rd_addr = to_addr(r_lo);
                n_state = S_L_SCAN;
            end
            S_RES_LOAD: begin
                n_res   = r_rd_data;
                n_state = S_RESP;
            end
            S_L_SCAN: begin
                if (r_rd_data.key <= r_pivot && r_l <= r_h && r_l < r_hi) begin
                    n_l     = r_l + PW'(1);
                    rd_addr = to_addr(r_l + PW'(1));
                end else begin
                    n_l_ent = r_rd_data;
                    rd_addr = to_addr(r_h);
                    n_state = S_H_SCAN;
                end
            end
            S_H_SCAN: begin
                if (r_rd_data.key >= r_pivot && r_h >= r_l && r_h > r_lo) begin
                    n_h     = r_h - PW'(1);
                    rd_addr = to_addr(r_h - PW'(1));
                end else if (r_l < r_h) begin
                    n_h_ent = r_rd_data;
                    n_state = S_SWAP_A;
                end else begin
                    n_h     = h_final;
                    rd_addr = to_addr(h_final);
                    n_state = S_PIV_RD;
                end
            end
            S_SWAP_A: begin
                wr_en   = 1'b1;
                wr_addr = to_addr(r_l);
                wr_data = r_h_ent;
                n_state = S_SWAP_B;
            end
            S_SWAP_B: begin
                wr_en   = 1'b1;
                wr_addr = to_addr(r_h);
                wr_data = r_l_ent;
                rd_addr = to_addr(r_l);
                n_state = S_L_SCAN;
            end
            S_PIV_RD: begin
                n_a     = r_rd_data;
                rd_addr = to_addr(r_mid);
                n_state = S_PIV_WA;
            end
            S_PIV_WA: begin
                wr_en   = 1'b1;
                wr_addr = to_addr(r_h);
                wr_data = r_rd_data;
                n_state = S_PIV_WB;
            end
            S_PIV_WB: begin
                wr_en   = 1'b1;
                wr_addr = to_addr(r_mid);
                wr_data = r_a;
                n_lo    = nx_lo;
                n_hi    = nx_hi;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                // reread the target: pivot of the next pass, or the result
                rd_addr = to_addr(r_mid);
                n_state = (r_hi > r_lo) ? S_PIV_LOAD : S_RES_LOAD;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_l        <= n_l;
        r_h        <= n_h;
        r_pivot    <= n_pivot;
        r_l_ent    <= n_l_ent;
        r_h_ent    <= n_h_ent;
        r_a        <= n_a;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

endmodule

// File: tb/sv/qsel_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class: shadow copy of the entry table and in-order result checking.
package qsel_scoreboard_pkg;
    import qsel_pkg::*;

    class qsel_scoreboard;
        bit [KW-1:0]     mirror_key     [DEPTH];
        bit [KW-1:0]     mirror_payload [DEPTH];
        // {payload, key} of every output transaction still owed by the block
        bit [OUT_DW-1:0] due_entries [$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            foreach (mirror_key[i]) begin
                mirror_key[i]     = '0;
                mirror_payload[i] = '0;
            end
        endfunction

        function bit in_table(t_pos p);
            return (p >= 1) && (p <= DEPTH);
        endfunction

        function void swap_entries(int a, int b);
            bit [KW-1:0] tk;
            bit [KW-1:0] tp;
            tk = mirror_key[a-1];
            tp = mirror_payload[a-1];
            mirror_key[a-1]     = mirror_key[b-1];
            mirror_payload[a-1] = mirror_payload[b-1];
            mirror_key[b-1]     = tk;
            mirror_payload[b-1] = tp;
        endfunction

        // Converging-scan quickselect; pivot is always the entry at mid.
        function void select_rank(int lo, int mid, int hi);
            int          l;
            int          h;
            bit [KW-1:0] pivot;
            while (hi > lo) begin
                l     = lo;
                h     = hi;
                pivot = mirror_key[mid-1];
                while (l < h) begin
                    while (mirror_key[l-1] <= pivot && l <= h && l < hi) l++;
                    while (mirror_key[h-1] >= pivot && h >= l && h > lo) h--;
                    if (l < h) swap_entries(l, h);
                end
                if (mid > h) h = l;
                swap_entries(h, mid);
                if (h >= mid) hi = h - 1;
                if (h <= mid) lo = h + 1;
            end
        endfunction

        function void note_input(t_op op, t_pos pos, bit [KW-1:0] key,
                                 bit [KW-1:0] payload, t_pos lo, t_pos tg, t_pos hi);
            bit [KW-1:0] out_key;
            bit [KW-1:0] out_payload;
            out_key     = '0;
            out_payload = '0;
            case (op)
                OP_WRITE: begin
                    if (in_table(pos)) begin
                        mirror_key[pos-1]     = key;
                        mirror_payload[pos-1] = payload;
                    end
                end
                OP_READ: begin
                    if (in_table(pos)) begin
                        out_key     = mirror_key[pos-1];
                        out_payload = mirror_payload[pos-1];
                    end
                end
                OP_PARTITION: begin
                    if (in_table(lo) && in_table(tg) && in_table(hi)) begin
                        select_rank(lo, tg, hi);
                        out_key     = mirror_key[tg-1];
                        out_payload = mirror_payload[tg-1];
                    end
                end
                default: ;
            endcase
            due_entries.push_back({out_payload, out_key});
        endfunction

        function void check_result(logic [OUT_DW-1:0] data);
            bit [OUT_DW-1:0] due;
            if (due_entries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction: key %h payload %h",
                             data[KW-1:0], data[OUT_DW-1:KW]);
                return;
            end
            due = due_entries.pop_front();
            if (data[KW-1:0] !== due[KW-1:0] || data[OUT_DW-1:KW] !== due[OUT_DW-1:KW]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output mismatch: key exp %h got %h, payload exp %h got %h",
                             due[KW-1:0], data[KW-1:0], due[OUT_DW-1:KW], data[OUT_DW-1:KW]);
            end
        endfunction

        function int unsigned pending();
            return due_entries.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (due_entries.size() == 0);
        endfunction
    endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: directed and random transactions driven into the partition engine.
module tb_top;
    import qsel_pkg::*;
    import qsel_scoreboard_pkg::*;

    // random transactions per idling phase; about 1600 items with directed and fill
    localparam int PHASE_ITEMS = 440;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_DW-1:0]    i_s_axis_tdata  = '0;
    logic [UW-1:0]       i_s_axis_tuser  = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   o_m_axis_tdata;

    // chance in percent that a side sits out a cycle
    int unsigned sender_idle_pct   = 27;
    int unsigned receiver_idle_pct = 67;

    qsel_scoreboard sb;

    always #10 i_clk = ~i_clk;

    quickselect_partition_engine_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Output side: sample the handshake as it stood before the edge, then pick
    // the ready level for the next cycle. One nonblocking write per edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
        i_m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Keys: half full-range, many small values so duplicates are common, plus
    // the two extremes of the unsigned compare.
    function automatic logic [KW-1:0] random_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return $urandom;
        if (r < 85) return $urandom_range(15);
        return r[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    function automatic t_pos random_position();
        return t_pos'($urandom_range(DEPTH, 1));
    endfunction

    // Position outside the table: zero or anything past DEPTH up to the 9-bit max.
    function automatic t_pos wild_position();
        if ($urandom_range(1)) return t_pos'(0);
        return t_pos'($urandom_range(511, DEPTH + 1));
    endfunction

    // Present one input transaction and wait until it is taken. tvalid is left
    // high on return; the next call either drives new data in the same step or
    // lowers it for an idle cycle, so it never toggles within one step.
    task automatic send_item(input t_op op, input t_pos pos, input logic [KW-1:0] key,
                             input logic [KW-1:0] payload, input t_pos lo,
                             input t_pos tg, input t_pos hi);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        // pad, high_bound, target, low_bound, payload, key, position (low bits last)
        i_s_axis_tdata  <= {4'b0000, hi, tg, lo, payload, key, pos};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(op, pos, key, payload, lo, tg, hi);
    endtask

    // Random mix once the whole table holds data: mostly partitions and
    // rewrites so the scan sees fresh orderings, a little noise on top.
    task automatic run_random_phase(input int count);
        int          r;
        int          w;
        t_op         op;
        t_pos        pos;
        t_pos        lo;
        t_pos        tg;
        t_pos        hi;
        logic [KW-1:0] key;
        logic [KW-1:0] payload;
        for (int n = 0; n < count; n++) begin
            op      = OP_NONE;
            pos     = t_pos'($urandom);
            key     = random_key();
            payload = $urandom;
            lo      = t_pos'($urandom);
            tg      = t_pos'($urandom);
            hi      = t_pos'($urandom);
            r       = $urandom_range(99);
            if (r < 30) begin
                op  = OP_WRITE;
                pos = random_position();
            end else if (r < 48) begin
                op  = OP_READ;
                pos = random_position();
            end else if (r < 90) begin
                op = OP_PARTITION;
                w  = $urandom_range(99);
                if (w < 2) begin
                    // whole table, kept rare since it is the widest and slowest range to partition
                    lo = t_pos'(1);
                    hi = t_pos'(DEPTH);
                end else begin
                    w  = (w < 88) ? $urandom_range(16, 1) : $urandom_range(64, 17);
                    lo = t_pos'($urandom_range(DEPTH - w + 1, 1));
                    hi = t_pos'(lo + w - 1);
                end
                r = $urandom_range(99);
                if (r < 85) begin
                    tg = t_pos'($urandom_range(hi, lo));
                end else if (r < 95) begin
                    // target anywhere, often outside the range
                    tg = random_position();
                end else begin
                    // reversed range
                    tg = random_position();
                    {lo, hi} = {hi, lo};
                end
            end else if (r < 94) begin
                op  = r[0] ? OP_WRITE : OP_READ;
                pos = wild_position();
            end else if (r < 97) begin
                op = OP_PARTITION;
                lo = random_position();
                tg = random_position();
                hi = random_position();
                case ($urandom_range(2))
                    0:       lo = wild_position();
                    1:       tg = wild_position();
                    default: hi = wild_position();
                endcase
            end
            send_item(op, pos, key, payload, lo, tg, hi);
        end
    endtask

    initial begin
        logic [KW-1:0] seed_keys [6];
        seed_keys = '{32'd5, 32'd3, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'h8000_0000};
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every operation, out-of-range cases.
        send_item(OP_WRITE, 9'd1, 32'h0000_0000, 32'hFFFF_FFFF, 9'd0, 9'd0, 9'd0);
        send_item(OP_WRITE, 9'd256, 32'hFFFF_FFFF, 32'h0000_0000, 9'd511, 9'd511, 9'd511);
        send_item(OP_READ, 9'd1, $urandom, $urandom, 9'd1, 9'd1, 9'd1);
        send_item(OP_READ, 9'd256, $urandom, $urandom, 9'd256, 9'd256, 9'd256);
        // position zero and past the end leave the table alone
        send_item(OP_WRITE, 9'd0, 32'hDEAD_BEEF, 32'h1234_5678, 9'd1, 9'd1, 9'd1);
        send_item(OP_WRITE, 9'd511, 32'hDEAD_BEEF, 32'h1234_5678, 9'd1, 9'd1, 9'd1);
        send_item(OP_READ, 9'd0, $urandom, $urandom, 9'd1, 9'd1, 9'd1);
        send_item(OP_READ, 9'd257, $urandom, $urandom, 9'd1, 9'd1, 9'd1);
        // unused operation code
        send_item(OP_NONE, 9'd3, $urandom, $urandom, 9'd1, 9'd2, 9'd3);
        for (int p = 2; p <= 7; p++) begin
            send_item(OP_WRITE, t_pos'(p), seed_keys[p-2], 32'h100 + p, 9'd0, 9'd0, 9'd0);
        end
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd1, 9'd4, 9'd7);
        // single-entry and reversed ranges
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd5, 9'd5, 9'd5);
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd7, 9'd3, 9'd2);
        // bounds outside the table
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd0, 9'd3, 9'd7);
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd1, 9'd3, 9'd300);
        // target outside the range, on either side
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd1, 9'd256, 9'd7);
        send_item(OP_PARTITION, 9'd0, $urandom, $urandom, 9'd5, 9'd1, 9'd7);
        send_item(OP_READ, 9'd4, $urandom, $urandom, 9'd0, 9'd0, 9'd0);
        send_item(OP_READ, 9'd256, $urandom, $urandom, 9'd0, 9'd0, 9'd0);

        // Fill every entry so later reads and partitions never touch unwritten data.
        for (int p = 1; p <= DEPTH; p++) begin
            send_item(OP_WRITE, t_pos'(p), random_key(), $urandom,
                      t_pos'($urandom), t_pos'($urandom), t_pos'($urandom));
        end

        run_random_phase(PHASE_ITEMS);
        sender_idle_pct   = 67;
        receiver_idle_pct = 27;
        run_random_phase(PHASE_ITEMS);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        i_s_axis_tvalid <= 1'b0;
        // drain, then wait for anything stray from the output register
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.clean()) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: many times the slowest legal run.
    initial begin
        #500_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
